>>> hw/rtl/dual_plane_flash_command_splitter_macros.svh
// Assertion macros for the checker file of the command splitter.
// Depends on nothing; users supply clk and rst in scope.
`ifndef DUAL_PLANE_FLASH_COMMAND_SPLITTER_MACROS_SVH
`define DUAL_PLANE_FLASH_COMMAND_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DPFCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DPFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/dpfcs_pkg.sv
// Package for the dual-plane flash command splitter: word types, codes and helpers.
// Depends on nothing.
package dpfcs_pkg;

  localparam int SUBPAGES_PER_PAGE  = 8;
  localparam int SUBPAGES_PER_PLANE = 4;

  localparam logic [2:0] REQ_READ     = 3'd0;
  localparam logic [2:0] REQ_WRITE    = 3'd1;
  localparam logic [2:0] REQ_GC_READ  = 3'd2;
  localparam logic [2:0] REQ_GC_WRITE = 3'd3;
  localparam logic [2:0] REQ_GC_ERASE = 3'd4;
  localparam logic [2:0] REQ_DUMMY    = 3'd5;
  localparam logic [2:0] REQ_TRIM     = 3'd6;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_ERASE = 3'd2;
  localparam logic [2:0] OP_DONE  = 3'd3;
  localparam logic [2:0] OP_ERROR = 3'd4;

  localparam logic [1:0] OOB_NONE   = 2'd0;
  localparam logic [1:0] OOB_FIRST  = 2'd1;
  localparam logic [1:0] OOB_SECOND = 2'd2;

  localparam logic [15:0] SECTOR_BYTES_RESET = 16'd4096;

  typedef struct packed {
    logic [2:0]  req_kind;
    logic [15:0] req_tag;
    logic [7:0]  channel;
    logic [7:0]  chip;
    logic [15:0] logical_block;
    logic [9:0]  page;
    logic [7:0]  subpage_mask;
  } req_t;

  typedef struct packed {
    logic [15:0] tag_out;
    logic [7:0]  channel_out;
    logic [7:0]  chip_out;
    logic [16:0] physical_block;
    logic [9:0]  page_out;
    logic [3:0]  plane_mask;
    logic [17:0] column_address;
    logic [2:0]  op_kind;
    logic        gc_op;
    logic        cmd_end;
    logic        multi_plane;
    logic [1:0]  oob_select;
  } cmd_t;

  typedef struct packed {
    cmd_t       first;
    cmd_t       second;
    logic [1:0] count;
  } cmd_pair_t;

  function automatic logic [1:0] lowest_index(input logic [3:0] m);
    logic [1:0] idx;
    idx = 2'd0;
    if (m[0]) idx = 2'd0;
    else if (m[1]) idx = 2'd1;
    else if (m[2]) idx = 2'd2;
    else if (m[3]) idx = 2'd3;
    return idx;
  endfunction

  function automatic logic [17:0] scale_column(input logic [15:0] size, input logic [1:0] idx);
    logic [17:0] a;
    logic [17:0] b;
    a = {2'b00, size} & {18{idx[0]}};
    b = {1'b0, size, 1'b0} & {18{idx[1]}};
    return a + b;
  endfunction

endpackage

>>> hw/rtl/dpfcs_decode.sv
// Splits one registered request into up to two plane commands.
// Depends on dpfcs_pkg.
module dpfcs_decode (
  input  dpfcs_pkg::req_t      req_q,
  input  logic [15:0]          sector_bytes,
  output dpfcs_pkg::cmd_pair_t pair
);
  import dpfcs_pkg::*;

  logic [3:0] lo;
  logic [3:0] hi;
  logic       is_gc;
  logic       run_on;
  logic [3:0] wr_m1;
  logic [3:0] wr_m2;
  cmd_t       base;
  cmd_t       lo_cmd;
  cmd_t       hi_cmd;

  assign lo = req_q.subpage_mask[3:0];
  assign hi = req_q.subpage_mask[7:4];
  assign run_on = &req_q.subpage_mask[4:1];
  assign wr_m1 = {&req_q.subpage_mask[3:1], &req_q.subpage_mask[2:1],
                  req_q.subpage_mask[1], 1'b1};
  assign wr_m2 = {&req_q.subpage_mask[7:5], &req_q.subpage_mask[6:5],
                  req_q.subpage_mask[5], 1'b1};

  always_comb begin
    is_gc = (req_q.req_kind == REQ_GC_READ) || (req_q.req_kind == REQ_GC_WRITE);

    base.tag_out        = req_q.req_tag;
    base.channel_out    = req_q.channel;
    base.chip_out       = req_q.chip;
    base.physical_block = {req_q.logical_block, 1'b0};
    base.page_out       = req_q.page;
    base.plane_mask     = 4'd0;
    base.column_address = 18'd0;
    base.op_kind        = OP_ERROR;
    base.gc_op          = 1'b0;
    base.cmd_end        = 1'b1;
    base.multi_plane    = 1'b0;
    base.oob_select     = OOB_NONE;

    lo_cmd = base;
    hi_cmd = base;
    hi_cmd.physical_block = {req_q.logical_block, 1'b1};
    pair.first  = base;
    pair.second = hi_cmd;
    pair.count  = 2'd1;

    case (req_q.req_kind)
      REQ_READ, REQ_GC_READ: begin
        lo_cmd.op_kind    = OP_READ;
        lo_cmd.gc_op      = is_gc;
        lo_cmd.plane_mask = lo;
        lo_cmd.cmd_end    = (hi == 4'd0);
        lo_cmd.oob_select = is_gc ? OOB_FIRST : OOB_NONE;
        lo_cmd.column_address = is_gc ? 18'd0 : scale_column(sector_bytes, lowest_index(lo));
        hi_cmd.op_kind    = OP_READ;
        hi_cmd.gc_op      = is_gc;
        hi_cmd.plane_mask = hi;
        hi_cmd.oob_select = is_gc ? OOB_SECOND : OOB_NONE;
        hi_cmd.column_address = is_gc ? 18'd0 : scale_column(sector_bytes, lowest_index(hi));
        pair.first  = (lo != 4'd0) ? lo_cmd : hi_cmd;
        pair.second = hi_cmd;
        pair.count  = {1'b0, |lo} + {1'b0, |hi};
      end
      REQ_WRITE, REQ_GC_WRITE: begin
        lo_cmd.op_kind     = OP_WRITE;
        lo_cmd.gc_op       = is_gc;
        lo_cmd.plane_mask  = wr_m1;
        lo_cmd.cmd_end     = !run_on;
        lo_cmd.multi_plane = run_on;
        lo_cmd.oob_select  = OOB_FIRST;
        hi_cmd.op_kind     = OP_WRITE;
        hi_cmd.gc_op       = is_gc;
        hi_cmd.plane_mask  = wr_m2;
        hi_cmd.oob_select  = OOB_SECOND;
        pair.first  = lo_cmd;
        pair.second = hi_cmd;
        pair.count  = run_on ? 2'd2 : 2'd1;
      end
      REQ_GC_ERASE: begin
        lo_cmd.op_kind = OP_ERASE;
        lo_cmd.gc_op   = 1'b1;
        lo_cmd.cmd_end = 1'b0;
        hi_cmd.op_kind = OP_ERASE;
        hi_cmd.gc_op   = 1'b1;
        pair.first  = lo_cmd;
        pair.second = hi_cmd;
        pair.count  = 2'd2;
      end
      REQ_DUMMY, REQ_TRIM: begin
        lo_cmd.op_kind = OP_DONE;
        pair.first = lo_cmd;
      end
      default: begin
        pair.first = base;
      end
    endcase
  end

endmodule

>>> hw/rtl/dpfcs_cmd_queue.sv
// Two-slot result register that hands out the commands of one request in order.
// Depends on dpfcs_pkg.
module dpfcs_cmd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pend_valid,
  input  dpfcs_pkg::cmd_pair_t pair,
  output logic                 take,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output dpfcs_pkg::cmd_t      cmd
);
  import dpfcs_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  cmd_t       slot0;
  cmd_t       slot1;

  assign cmd_valid = (count != 2'd0);
  assign cmd = slot0;
  assign take = pend_valid && ((count == 2'd0) || ((count == 2'd1) && cmd_ready));

  always_comb begin
    count_next = count;
    if (take) begin
      count_next = pair.count;
    end else if (cmd_valid && cmd_ready) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0 <= pair.first;
      slot1 <= pair.second;
    end else if (cmd_valid && cmd_ready) begin
      slot0 <= slot1;
    end
  end

endmodule

>>> hw/rtl/dual_plane_flash_command_splitter.sv
// Top level of the dual-plane flash command splitter.
// Depends on dpfcs_pkg, dpfcs_decode and dpfcs_cmd_queue.
//
//   Channel  Direction  Handshake                 Word
//   req      in         req_valid / req_ready     dpfcs_pkg::req_t
//   cmd      out        cmd_valid / cmd_ready     dpfcs_pkg::cmd_t
//   cfg      in         cfg_wr_en                 cfg_wr_data, bytes per subpage
//
// A request is registered in req_q, then decoded into the result slots once they can take it.
// The single result port sets the pace: while cmd_ready holds, a new request is taken
// as the last command of the one before leaves, so requests overlap at the port.
// Reset clears the request and result valid state and loads 4096 bytes per subpage.
// A stalled result holds; the input register takes one further request, then holds it until a slot frees.
module dual_plane_flash_command_splitter (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  dpfcs_pkg::req_t  req,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output dpfcs_pkg::cmd_t  cmd,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);
  import dpfcs_pkg::*;

  logic      pend_valid;
  req_t      req_q;
  logic [15:0] sector_bytes;
  cmd_pair_t pair;
  logic      take;

  assign req_ready = !pend_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      sector_bytes <= SECTOR_BYTES_RESET;
    end else begin
      if (req_valid && req_ready) begin
        pend_valid <= 1'b1;
      end else if (take) begin
        pend_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        sector_bytes <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  dpfcs_decode u_decode (
    .req_q        (req_q),
    .sector_bytes (sector_bytes),
    .pair         (pair)
  );

  dpfcs_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pair       (pair),
    .take       (take),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

endmodule

>>> hw/rtl/dpfcs_checker.sv
// Port-level checks on the command output of the splitter, bound to the top level.
// Depends on dpfcs_pkg and dual_plane_flash_command_splitter_macros.svh.
`include "dual_plane_flash_command_splitter_macros.svh"

module dpfcs_checker (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_ready,
  input dpfcs_pkg::cmd_t cmd
);
  import dpfcs_pkg::*;

  logic cmd_stall;
  logic first_out;
  logic second_ok;
  logic is_done;
  logic mp_ok;
  logic done_ok;

  assign cmd_stall = cmd_valid && !cmd_ready;
  assign first_out = cmd_valid && cmd_ready && !cmd.cmd_end;
  assign second_ok = cmd_valid && cmd.physical_block[0];
  assign is_done   = (cmd.op_kind == OP_DONE) || (cmd.op_kind == OP_ERROR);
  assign mp_ok     = (cmd.op_kind == OP_WRITE) && !cmd.cmd_end && !cmd.physical_block[0];
  assign done_ok   = cmd.cmd_end && (cmd.plane_mask == 4'd0) && !cmd.physical_block[0];

  // A stalled command word stays on the port unchanged.
  `DPFCS_ASSERT_NEXT(a_cmd_hold, cmd_stall, cmd_valid && $stable(cmd), "cmd changed while stalled")

  // A command without the end mark is followed at once by the second-plane command.
  `DPFCS_ASSERT_NEXT(a_second_follows, first_out, second_ok, "second command missing")

  // Multi-plane marks only a first-plane write that is not the last.
  `DPFCS_ASSERT_NOW(a_multi_plane, cmd_valid && cmd.multi_plane, mp_ok, "bad multi-plane mark")

  // Completions and errors are single, first-plane, empty words.
  `DPFCS_ASSERT_NOW(a_single_done, cmd_valid && is_done, done_ok, "bad completion word")

endmodule

bind dual_plane_flash_command_splitter dpfcs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd)
);

>>> tb/dual_plane_flash_command_splitter_tb.sv
// Self-checking testbench for the dual-plane flash command splitter.
// Depends on dpfcs_pkg and dual_plane_flash_command_splitter; predicts every command word
// in a local model and checks it against the result port under always-ready, random and patterned back-pressure.
`timescale 1ns / 100ps

module dual_plane_flash_command_splitter_tb;
  import dpfcs_pkg::*;

  localparam logic [2:0] REQ_INVALID = 3'd7;

  localparam int READY_ALWAYS  = 0;
  localparam int READY_RANDOM  = 1;
  localparam int READY_PATTERN = 2;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        cmd_valid;
  logic        cmd_ready = 1'b0;
  cmd_t        cmd;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  cmd_t        pending_cmds[$];
  logic [15:0] model_sector_bytes = SECTOR_BYTES_RESET;
  int          mismatch_count = 0;
  int          ready_mode = READY_ALWAYS;
  int          hold_off_cycles = 0;
  logic [31:0] ready_tick = 0;

  dual_plane_flash_command_splitter i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("dual_plane_flash_command_splitter_tb: done, errors");
    $finish;
  end

  function automatic logic [1:0] first_set_index(input logic [3:0] m);
    logic [1:0] idx;
    int i;
    idx = 2'd0;
    for (i = 3; i >= 0; i--) begin
      if (m[i]) idx = 2'(i);
    end
    return idx;
  endfunction

  function automatic cmd_t make_cmd(input req_t r, input logic plane, input logic [3:0] pmask,
                                    input logic [17:0] col, input logic [2:0] kind,
                                    input logic gc, input logic last, input logic mp,
                                    input logic [1:0] oob);
    cmd_t c;
    c.tag_out        = r.req_tag;
    c.channel_out    = r.channel;
    c.chip_out       = r.chip;
    c.physical_block = {r.logical_block, plane};
    c.page_out       = r.page;
    c.plane_mask     = pmask;
    c.column_address = col;
    c.op_kind        = kind;
    c.gc_op          = gc;
    c.cmd_end        = last;
    c.multi_plane    = mp;
    c.oob_select     = oob;
    return c;
  endfunction

  function automatic logic [17:0] column_of(input logic [3:0] m);
    return {2'b00, model_sector_bytes} * {16'd0, first_set_index(m)};
  endfunction

  task automatic predict_commands(input req_t r);
    logic [3:0] lo;
    logic [3:0] hi;
    logic [3:0] m1;
    logic [3:0] m2;
    logic       gc;
    logic       run_on;
    logic       run2;
    int         i;
    lo = r.subpage_mask[3:0];
    hi = r.subpage_mask[7:4];
    case (r.req_kind)
      REQ_READ, REQ_GC_READ: begin
        gc = (r.req_kind == REQ_GC_READ);
        if (lo != 4'd0) begin
          pending_cmds.push_back(make_cmd(r, 1'b0, lo, gc ? 18'd0 : column_of(lo), OP_READ, gc,
                                          hi == 4'd0, 1'b0, gc ? OOB_FIRST : OOB_NONE));
        end
        if (hi != 4'd0) begin
          pending_cmds.push_back(make_cmd(r, 1'b1, hi, gc ? 18'd0 : column_of(hi), OP_READ, gc,
                                          1'b1, 1'b0, gc ? OOB_SECOND : OOB_NONE));
        end
      end
      REQ_WRITE, REQ_GC_WRITE: begin
        gc = (r.req_kind == REQ_GC_WRITE);
        m1 = 4'd0;
        m2 = 4'd0;
        run_on = 1'b1;
        for (i = 0; i < 4; i++) begin
          if (run_on) begin
            m1[i] = 1'b1;
            if (!r.subpage_mask[i+1]) run_on = 1'b0;
          end
        end
        pending_cmds.push_back(make_cmd(r, 1'b0, m1, 18'd0, OP_WRITE, gc, !run_on, run_on,
                                        OOB_FIRST));
        if (run_on) begin
          run2 = 1'b1;
          for (i = 4; i < 8; i++) begin
            if (run2) begin
              m2[i-4] = 1'b1;
              if (i == 7) run2 = 1'b0;
              else if (!r.subpage_mask[i+1]) run2 = 1'b0;
            end
          end
          pending_cmds.push_back(make_cmd(r, 1'b1, m2, 18'd0, OP_WRITE, gc, 1'b1, 1'b0,
                                          OOB_SECOND));
        end
      end
      REQ_GC_ERASE: begin
        pending_cmds.push_back(make_cmd(r, 1'b0, 4'd0, 18'd0, OP_ERASE, 1'b1, 1'b0, 1'b0,
                                        OOB_NONE));
        pending_cmds.push_back(make_cmd(r, 1'b1, 4'd0, 18'd0, OP_ERASE, 1'b1, 1'b1, 1'b0,
                                        OOB_NONE));
      end
      REQ_DUMMY, REQ_TRIM: begin
        pending_cmds.push_back(make_cmd(r, 1'b0, 4'd0, 18'd0, OP_DONE, 1'b0, 1'b1, 1'b0,
                                        OOB_NONE));
      end
      default: begin
        pending_cmds.push_back(make_cmd(r, 1'b0, 4'd0, 18'd0, OP_ERROR, 1'b0, 1'b1, 1'b0,
                                        OOB_NONE));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] tag,
                             input logic [17:0] exp_val, input logic [17:0] act_val);
    if (exp_val !== act_val) begin
      if (mismatch_count < 10) begin
        $display("mismatch in %s, tag %h: expected %0h, actual %0h", name, tag, exp_val, act_val);
      end
      mismatch_count++;
    end
  endtask

  task automatic compare_command(input cmd_t got);
    cmd_t want;
    if (pending_cmds.size() == 0) begin
      if (mismatch_count < 10) begin
        $display("unexpected command word, tag %h, op_kind %0d", got.tag_out, got.op_kind);
      end
      mismatch_count++;
    end else begin
      want = pending_cmds.pop_front();
      check_field("tag_out", want.tag_out, 18'(want.tag_out), 18'(got.tag_out));
      check_field("channel_out", want.tag_out, 18'(want.channel_out), 18'(got.channel_out));
      check_field("chip_out", want.tag_out, 18'(want.chip_out), 18'(got.chip_out));
      check_field("physical_block", want.tag_out, 18'(want.physical_block),
                  18'(got.physical_block));
      check_field("page_out", want.tag_out, 18'(want.page_out), 18'(got.page_out));
      check_field("plane_mask", want.tag_out, 18'(want.plane_mask), 18'(got.plane_mask));
      check_field("column_address", want.tag_out, want.column_address, got.column_address);
      check_field("op_kind", want.tag_out, 18'(want.op_kind), 18'(got.op_kind));
      check_field("gc_op", want.tag_out, 18'(want.gc_op), 18'(got.gc_op));
      check_field("cmd_end", want.tag_out, 18'(want.cmd_end), 18'(got.cmd_end));
      check_field("multi_plane", want.tag_out, 18'(want.multi_plane), 18'(got.multi_plane));
      check_field("oob_select", want.tag_out, 18'(want.oob_select), 18'(got.oob_select));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && cmd_valid && cmd_ready) compare_command(cmd);
    end
  end

  // The receiver counts down a requested hold-off itself, then falls back to its mode.
  initial begin
    forever begin
      @(posedge clk);
      ready_tick <= ready_tick + 1;
      if (hold_off_cycles > 0) begin
        hold_off_cycles = hold_off_cycles - 1;
        cmd_ready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: cmd_ready <= 1'b1;
          READY_RANDOM: cmd_ready <= ($urandom_range(0, 99) < 55);
          default: cmd_ready <= ((ready_tick % 7) < 4) || (ready_tick[5:4] == 2'b11);
        endcase
      end
    end
  end

  task automatic send_request(input req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_commands(r);
  endtask

  task automatic pause_requests(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_until_idle();
    req_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sector_bytes(input logic [15:0] size);
    wait_until_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_sector_bytes = size;
  endtask

  function automatic req_t build_request(input logic [2:0] kind, input logic [7:0] mask,
                                         input logic ones);
    req_t r;
    r.req_kind      = kind;
    r.req_tag       = ones ? 16'hFFFF : 16'h0000;
    r.channel       = ones ? 8'hFF : 8'h00;
    r.chip          = ones ? 8'hFF : 8'h00;
    r.logical_block = ones ? 16'hFFFF : 16'h0000;
    r.page          = ones ? 10'h3FF : 10'h000;
    r.subpage_mask  = mask;
    return r;
  endfunction

  function automatic req_t random_request(input bit reads_only);
    req_t        r;
    int          pick;
    int          len;
    logic [8:0]  run;
    logic [8:0]  above;
    pick = reads_only ? $urandom_range(0, 44) : $urandom_range(0, 99);
    r.req_tag = 16'($urandom);
    r.channel = 8'($urandom);
    r.chip    = 8'($urandom);
    r.page    = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 7))
      0: r.logical_block = 16'h0000;
      1: r.logical_block = 16'hFFFF;
      default: r.logical_block = 16'($urandom);
    endcase
    if (pick < 30) r.req_kind = REQ_READ;
    else if (pick < 45) r.req_kind = REQ_GC_READ;
    else if (pick < 70) r.req_kind = REQ_WRITE;
    else if (pick < 80) r.req_kind = REQ_GC_WRITE;
    else if (pick < 88) r.req_kind = REQ_GC_ERASE;
    else if (pick < 93) r.req_kind = REQ_DUMMY;
    else if (pick < 97) r.req_kind = REQ_TRIM;
    else r.req_kind = REQ_INVALID;
    r.subpage_mask = 8'($urandom);
    if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) r.subpage_mask[3:0] = 4'd0;
      if ($urandom_range(0, 3) == 0) r.subpage_mask[7:4] = 4'd0;
    end else if (pick < 80 && $urandom_range(0, 9) < 7) begin
      len = $urandom_range(1, 8);
      run = (9'd1 << len) - 9'd1;
      above = 9'($urandom) & ~((9'd1 << len) | run);
      r.subpage_mask = 8'(run | above);
      r.subpage_mask[0] = 1'($urandom);
    end
    return r;
  endfunction

  task automatic send_traffic(input int count, input bit reads_only);
    int sent;
    int burst;
    int gap;
    int j;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (j = 0; j < burst && sent < count; j++) begin
        send_request(random_request(reads_only));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) pause_requests(gap);
    end
  endtask

  task automatic test_directed_at_reset();
    req_t items[$];
    int   i;
    ready_mode = READY_RANDOM;
    items.push_back(build_request(REQ_READ, 8'hFF, 1'b1));
    items.push_back(build_request(REQ_READ, 8'h00, 1'b0));
    items.push_back(build_request(REQ_READ, 8'h0F, 1'b0));
    items.push_back(build_request(REQ_READ, 8'hF0, 1'b1));
    items.push_back(build_request(REQ_READ, 8'h08, 1'b1));
    items.push_back(build_request(REQ_READ, 8'h48, 1'b0));
    items.push_back(build_request(REQ_GC_READ, 8'hA5, 1'b1));
    items.push_back(build_request(REQ_GC_READ, 8'h00, 1'b0));
    items.push_back(build_request(REQ_GC_READ, 8'h30, 1'b0));
    items.push_back(build_request(REQ_WRITE, 8'h00, 1'b0));
    items.push_back(build_request(REQ_WRITE, 8'h03, 1'b1));
    items.push_back(build_request(REQ_WRITE, 8'h0F, 1'b0));
    items.push_back(build_request(REQ_WRITE, 8'h1F, 1'b1));
    items.push_back(build_request(REQ_WRITE, 8'hFF, 1'b0));
    items.push_back(build_request(REQ_WRITE, 8'h7E, 1'b1));
    items.push_back(build_request(REQ_GC_WRITE, 8'h3F, 1'b0));
    items.push_back(build_request(REQ_GC_WRITE, 8'h05, 1'b1));
    items.push_back(build_request(REQ_GC_ERASE, 8'h00, 1'b0));
    items.push_back(build_request(REQ_GC_ERASE, 8'hFF, 1'b1));
    items.push_back(build_request(REQ_DUMMY, 8'hFF, 1'b0));
    items.push_back(build_request(REQ_TRIM, 8'h00, 1'b1));
    items.push_back(build_request(REQ_INVALID, 8'h5A, 1'b0));
    items.push_back(build_request(REQ_INVALID, 8'hFF, 1'b1));
    for (i = 0; i < items.size(); i++) begin
      send_request(items[i]);
      if ($urandom_range(0, 2) == 0) pause_requests($urandom_range(1, 3));
    end
    wait_until_idle();
  endtask

  task automatic test_sector_bytes_extremes();
    logic [15:0] sizes[4];
    int          k;
    sizes[0] = 16'd0;
    sizes[1] = 16'hFFFF;
    sizes[2] = 16'd1;
    sizes[3] = 16'($urandom);
    ready_mode = READY_PATTERN;
    for (k = 0; k < 4; k++) begin
      set_sector_bytes(sizes[k]);
      send_request(build_request(REQ_READ, 8'h88, 1'b1));
      send_traffic(9, 1'b1);
    end
    wait_until_idle();
  endtask

  task automatic test_output_backpressure();
    int j;
    ready_mode = READY_ALWAYS;
    hold_off_cycles = 400;
    for (j = 0; j < 30; j++) send_request(random_request(1'b0));
    wait_until_idle();
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      ready_mode = phase % 3;
      if (phase % 2 == 1) set_sector_bytes(16'($urandom));
      send_traffic(PHASE_ITEMS, 1'b0);
      wait_until_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_at_reset();
    test_sector_bytes_extremes();
    test_output_backpressure();
    test_random_traffic();
    req_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("dual_plane_flash_command_splitter_tb: done, clean");
    end else begin
      $display("dual_plane_flash_command_splitter_tb: done, errors");
    end
    $finish;
  end

endmodule
